// File: design/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types, codes and helpers for the maze backtracker step block.
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int COORD_W = 5;
  localparam int MODE_W  = 2;
  localparam int DRAW_W  = 2;
  localparam int CFG_W   = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] GRID_W_RST = 6'd16;
  localparam logic [CFG_W-1:0] GRID_H_RST = 6'd8;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;

  localparam logic [DRAW_W-1:0] DIR_E = 2'd0;
  localparam logic [DRAW_W-1:0] DIR_W = 2'd1;
  localparam logic [DRAW_W-1:0] DIR_S = 2'd2;
  localparam logic [DRAW_W-1:0] DIR_N = 2'd3;

  // Cell bit planes.
  localparam int NUM_PL = 5;
  localparam int PL_VIS = 0;
  localparam int PL_N   = 1;
  localparam int PL_S   = 2;
  localparam int PL_E   = 3;
  localparam int PL_W   = 4;

  typedef enum logic [2:0] {
    ST_STARTED,
    ST_CARVED,
    ST_REJECTED,
    ST_BACKTRACK,
    ST_FINISHED,
    ST_READ,
    ST_NOT_STARTED
  } status_e;

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_WALK,
    RUN_DONE
  } run_e;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_EXEC,
    CS_START
  } ctl_e;

  typedef struct packed {
    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
    logic             wr;
  } cfg_t;

  function automatic logic [2:0] here_plane(input logic [DRAW_W-1:0] d);
    logic [2:0] p;
    case (d)
      DIR_E:   p = 3'(PL_E);
      DIR_W:   p = 3'(PL_W);
      DIR_S:   p = 3'(PL_S);
      default: p = 3'(PL_N);
    endcase
    return p;
  endfunction

  function automatic logic [2:0] there_plane(input logic [DRAW_W-1:0] d);
    logic [2:0] p;
    case (d)
      DIR_E:   p = 3'(PL_W);
      DIR_W:   p = 3'(PL_E);
      DIR_S:   p = 3'(PL_N);
      default: p = 3'(PL_S);
    endcase
    return p;
  endfunction

endpackage

// File: design/mbs_ram.sv
// ----------------------------------------------------------------------------
// mbs_ram
// Generic memory with one write port and NRD registered read ports.
// ----------------------------------------------------------------------------
module mbs_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  parameter int NRD   = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i [NRD],
  output logic [WIDTH-1:0]         rdata_o [NRD]
);

  logic [WIDTH-1:0] mem_q   [DEPTH];
  logic [WIDTH-1:0] rdata_q [NRD];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      for (int i = 0; i < NRD; i++) begin
        rdata_q[i] <= mem_q[raddr_i[i]];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mbs_cfg.sv
// ----------------------------------------------------------------------------
// mbs_cfg
// APB-style register port holding the grid width and height.
// ----------------------------------------------------------------------------
module mbs_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbs_pkg::PADDR_W-1:0] paddr,
  input  logic [mbs_pkg::PDATA_W-1:0] pwdata,
  output logic [mbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output mbs_pkg::cfg_t               cfg_o
);

  logic [mbs_pkg::CFG_W-1:0] width_q, width_d;
  logic [mbs_pkg::CFG_W-1:0] height_q, height_d;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr) begin
      unique case (paddr[2])
        mbs_pkg::REG_GRID_WIDTH:  width_d  = pwdata[mbs_pkg::CFG_W-1:0];
        mbs_pkg::REG_GRID_HEIGHT: height_d = pwdata[mbs_pkg::CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mbs_pkg::REG_GRID_WIDTH:  prdata = mbs_pkg::PDATA_W'(width_q);
      mbs_pkg::REG_GRID_HEIGHT: prdata = mbs_pkg::PDATA_W'(height_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbs_pkg::GRID_W_RST;
      height_q <= mbs_pkg::GRID_H_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.grid_width  = width_q;
  assign cfg_o.grid_height = height_q;
  assign cfg_o.wr          = wr;

endmodule

// File: design/maze_backtracker_step.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step
// Randomized depth-first maze carver, one walk iteration per step transaction.
//
// The input channel carries a mode (start, step, read), a cell position and
// a 2-bit direction draw; every accepted transaction yields exactly one
// result transaction with a status, a position and the read cell's bits.
// Grid width and height are set through the APB-style register port; the user
// must write them only while the block is idle; the block does not enforce it.
// A write returns the walk to the not-started state. Accepting a step or read
// issues the reads of the four neighbor cells (two x-parity banks with two
// read ports each) and of the stack top, or of the requested cell for a read;
// the execute state, once the output is free, decides, writes the cell planes
// and the stack and loads the result register. A start first sweeps all cell
// planes over MAX_HEIGHT times ceil(MAX_WIDTH/2) bank addresses (512 at the
// default size). The same clearing pass runs after reset; no transaction is
// accepted then. A stalled result holds in the output register while the next
// transaction is taken; the block waits only when a second result is ready.
// ----------------------------------------------------------------------------
module maze_backtracker_step #(
  parameter int MAX_WIDTH   = 32,
  parameter int MAX_HEIGHT  = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbs_pkg::PADDR_W-1:0] paddr,
  input  logic [mbs_pkg::PDATA_W-1:0] pwdata,
  output logic [mbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mbs_pkg::MODE_W-1:0]  mode_i,
  input  logic [mbs_pkg::COORD_W-1:0] cell_x_i,
  input  logic [mbs_pkg::COORD_W-1:0] cell_y_i,
  input  logic [mbs_pkg::DRAW_W-1:0]  draw_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [mbs_pkg::COORD_W-1:0] pos_x_o,
  output logic [mbs_pkg::COORD_W-1:0] pos_y_o,
  output logic                        open_north_o,
  output logic                        open_south_o,
  output logic                        open_east_o,
  output logic                        open_west_o,
  output logic                        cell_visited_o
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int DW     = $clog2(MAX_WIDTH + 1);
  localparam int DH     = $clog2(MAX_HEIGHT + 1);
  localparam int KA     = (DW > DH) ? DW : DH;
  localparam int K      = (KA > mbs_pkg::COORD_W) ? KA : mbs_pkg::COORD_W;
  localparam int HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int BANK_D = MAX_HEIGHT * HALF_W;
  localparam int BAW    = $clog2(BANK_D);
  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW     = $clog2(CELLS + 1);
  localparam int SPW    = $clog2(STACK_DEPTH);
  localparam int SDW    = $clog2(STACK_DEPTH + 1);
  localparam int NOP    = mbs_pkg::NUM_PL - 1;

  function automatic logic [BAW-1:0] bank_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
    return BAW'(int'(y) * HALF_W + int'(x >> 1));
  endfunction

  mbs_pkg::cfg_t cfg;

  mbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbs_pkg::ctl_e ctl_q, ctl_d;
  mbs_pkg::run_e run_q, run_d;
  logic                         pend_q, pend_d;
  logic [BAW-1:0]               clr_q, clr_d;
  logic [XW-1:0]                walk_x_q, walk_x_d;
  logic [YW-1:0]                walk_y_q, walk_y_d;
  logic [SDW-1:0]               depth_q, depth_d;
  logic [CW-1:0]                vcnt_q, vcnt_d;

  logic [mbs_pkg::MODE_W-1:0]   mode_q;
  logic [mbs_pkg::COORD_W-1:0]  cx_q, cy_q;
  logic [mbs_pkg::DRAW_W-1:0]   draw_q;
  logic                         ingrid_q;

  logic                         ov_q;
  mbs_pkg::status_e             status_q;
  logic [mbs_pkg::COORD_W-1:0]  px_q, py_q;
  logic [mbs_pkg::NUM_PL-1:0]   obits_q;

  logic [DW-1:0]                w_eff;
  logic [DH-1:0]                h_eff;
  logic [CW-1:0]                area;

  logic                         acc;
  logic                         is_read_in;
  logic                         ingrid_in;
  logic [K-1:0]                 sx_k, sy_k;
  logic [BAW-1:0]               rd_addr;
  logic [BAW-1:0]               e_addr, w_addr, n_addr, s_addr, cur_addr, new_addr;

  logic [BAW-1:0]               vis_ra [2][2];
  logic [0:0]                   vis_rd [2][2];
  logic [BAW-1:0]               opn_ra [1];
  logic [0:0]                   opn_rd [NOP][2][1];

  logic                         pl_we [mbs_pkg::NUM_PL][2];
  logic [BAW-1:0]               pl_wa [mbs_pkg::NUM_PL][2];
  logic [0:0]                   pl_wd;
  logic                         clearing;

  logic                         stk_we;
  logic [SPW-1:0]               stk_wa;
  logic [XW+YW-1:0]             stk_wd;
  logic [SPW-1:0]               stk_ra [1];
  logic [XW+YW-1:0]             stk_rd [1];
  logic [SDW-1:0]               depth_m1;

  logic                         x0, nb, cx0;
  logic [3:0]                   ok;
  logic [XW-1:0]                nx;
  logic [YW-1:0]                ny;
  logic [2:0]                   here, there;
  logic                         is_read_q;
  logic                         out_free;
  logic                         fire;
  mbs_pkg::status_e             res_status;
  logic [mbs_pkg::NUM_PL-1:0]   res_bits;

  // Effective grid size, clamped to 1..MAX.
  always_comb begin
    if (cfg.grid_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(cfg.grid_width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(cfg.grid_width);
    end
    if (cfg.grid_height == '0) begin
      h_eff = DH'(1);
    end else if (32'(cfg.grid_height) > MAX_HEIGHT) begin
      h_eff = DH'(MAX_HEIGHT);
    end else begin
      h_eff = DH'(cfg.grid_height);
    end
  end

  assign area = CW'(w_eff) * CW'(h_eff);

  // Input side: acceptance and read addresses issued in the same cycle.
  assign in_stall_o = (ctl_q != mbs_pkg::CS_IDLE);
  assign acc        = in_valid_i && (ctl_q == mbs_pkg::CS_IDLE);
  assign is_read_in = !(mode_i == mbs_pkg::MODE_START || mode_i == mbs_pkg::MODE_STEP);
  assign ingrid_in  = (K'(cell_x_i) < K'(w_eff)) && (K'(cell_y_i) < K'(h_eff));
  assign sx_k = (K'(cell_x_i) >= K'(w_eff)) ? K'(w_eff) - K'(1) : K'(cell_x_i);
  assign sy_k = (K'(cell_y_i) >= K'(h_eff)) ? K'(h_eff) - K'(1) : K'(cell_y_i);
  assign rd_addr = ingrid_in ? bank_addr(XW'(cell_x_i), YW'(cell_y_i)) : '0;

  assign e_addr   = bank_addr(walk_x_q + XW'(1), walk_y_q);
  assign w_addr   = bank_addr(walk_x_q - XW'(1), walk_y_q);
  assign s_addr   = bank_addr(walk_x_q, walk_y_q + YW'(1));
  assign n_addr   = bank_addr(walk_x_q, walk_y_q - YW'(1));
  assign cur_addr = bank_addr(walk_x_q, walk_y_q);
  assign x0       = walk_x_q[0];
  assign nb       = ~walk_x_q[0];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (is_read_in) begin
        vis_ra[b][0] = rd_addr;
        vis_ra[b][1] = rd_addr;
      end else if (1'(b) != x0) begin
        vis_ra[b][0] = e_addr;
        vis_ra[b][1] = w_addr;
      end else begin
        vis_ra[b][0] = n_addr;
        vis_ra[b][1] = s_addr;
      end
    end
  end

  assign opn_ra[0] = rd_addr;
  assign depth_m1  = depth_q - SDW'(1);
  assign stk_ra[0] = depth_m1[SPW-1:0];
  assign pl_wd     = ~clearing;

  // Cell planes, each split into two banks by x parity.
  for (genvar b = 0; b < 2; b++) begin : g_vis
    mbs_ram #(
      .DEPTH (BANK_D),
      .WIDTH (1),
      .NRD   (2)
    ) u_vis (
      .clk_i   (clk_i),
      .we_i    (pl_we[mbs_pkg::PL_VIS][b]),
      .waddr_i (pl_wa[mbs_pkg::PL_VIS][b]),
      .wdata_i (pl_wd),
      .re_i    (acc),
      .raddr_i (vis_ra[b]),
      .rdata_o (vis_rd[b])
    );
  end

  for (genvar q = 0; q < NOP; q++) begin : g_opn
    for (genvar b = 0; b < 2; b++) begin : g_bank
      mbs_ram #(
        .DEPTH (BANK_D),
        .WIDTH (1),
        .NRD   (1)
      ) u_opn (
        .clk_i   (clk_i),
        .we_i    (pl_we[mbs_pkg::PL_N+q][b]),
        .waddr_i (pl_wa[mbs_pkg::PL_N+q][b]),
        .wdata_i (pl_wd),
        .re_i    (acc),
        .raddr_i (opn_ra),
        .rdata_o (opn_rd[q][b])
      );
    end
  end

  mbs_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (XW + YW),
    .NRD   (1)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_wa),
    .wdata_i (stk_wd),
    .re_i    (acc),
    .raddr_i (stk_ra),
    .rdata_o (stk_rd)
  );

  // Decision datapath on the registered neighbor data.
  assign ok[0] = (K'(walk_x_q) + K'(1) < K'(w_eff)) && !vis_rd[nb][0][0];
  assign ok[1] = (walk_x_q != '0) && !vis_rd[nb][1][0];
  assign ok[2] = (K'(walk_y_q) + K'(1) < K'(h_eff)) && !vis_rd[x0][1][0];
  assign ok[3] = (walk_y_q != '0) && !vis_rd[x0][0][0];

  always_comb begin
    nx = walk_x_q;
    ny = walk_y_q;
    case (draw_q)
      mbs_pkg::DIR_E: nx = walk_x_q + XW'(1);
      mbs_pkg::DIR_W: nx = walk_x_q - XW'(1);
      mbs_pkg::DIR_S: ny = walk_y_q + YW'(1);
      default:        ny = walk_y_q - YW'(1);
    endcase
  end

  assign new_addr  = bank_addr(nx, ny);
  assign here      = mbs_pkg::here_plane(draw_q);
  assign there     = mbs_pkg::there_plane(draw_q);
  assign is_read_q = !(mode_q == mbs_pkg::MODE_START || mode_q == mbs_pkg::MODE_STEP);
  assign cx0       = cx_q[0];
  assign out_free  = !ov_q || !out_stall_i;

  always_comb begin
    ctl_d      = ctl_q;
    pend_d     = pend_q;
    clr_d      = clr_q;
    walk_x_d   = walk_x_q;
    walk_y_d   = walk_y_q;
    depth_d    = depth_q;
    vcnt_d     = vcnt_q;
    run_d      = run_q;
    fire       = 1'b0;
    clearing   = 1'b0;
    res_status = mbs_pkg::ST_READ;
    res_bits   = '0;
    stk_we     = 1'b0;
    stk_wa     = '0;
    stk_wd     = '0;
    for (int p = 0; p < mbs_pkg::NUM_PL; p++) begin
      for (int b = 0; b < 2; b++) begin
        pl_we[p][b] = 1'b0;
        pl_wa[p][b] = '0;
      end
    end

    unique case (ctl_q)
      mbs_pkg::CS_CLEAR: begin
        clearing = 1'b1;
        clr_d    = clr_q + BAW'(1);
        for (int p = 0; p < mbs_pkg::NUM_PL; p++) begin
          for (int b = 0; b < 2; b++) begin
            pl_we[p][b] = 1'b1;
            pl_wa[p][b] = clr_q;
          end
        end
        if (clr_q == BAW'(BANK_D - 1)) begin
          clr_d  = '0;
          pend_d = 1'b0;
          ctl_d  = pend_q ? mbs_pkg::CS_START : mbs_pkg::CS_IDLE;
        end
      end
      mbs_pkg::CS_IDLE: begin
        if (acc) begin
          if (mode_i == mbs_pkg::MODE_START) begin
            ctl_d    = mbs_pkg::CS_CLEAR;
            pend_d   = 1'b1;
            walk_x_d = sx_k[XW-1:0];
            walk_y_d = sy_k[YW-1:0];
          end else begin
            ctl_d = mbs_pkg::CS_EXEC;
          end
        end
      end
      mbs_pkg::CS_START: begin
        if (out_free) begin
          fire                        = 1'b1;
          ctl_d                       = mbs_pkg::CS_IDLE;
          pl_we[mbs_pkg::PL_VIS][x0] = 1'b1;
          pl_wa[mbs_pkg::PL_VIS][x0] = cur_addr;
          stk_we                      = 1'b1;
          stk_wa                      = '0;
          stk_wd                      = {walk_y_q, walk_x_q};
          depth_d                     = SDW'(1);
          vcnt_d                      = CW'(1);
          run_d      = (CW'(1) >= area) ? mbs_pkg::RUN_DONE : mbs_pkg::RUN_WALK;
          res_status = mbs_pkg::ST_STARTED;
        end
      end
      mbs_pkg::CS_EXEC: begin
        if (out_free) begin
          fire  = 1'b1;
          ctl_d = mbs_pkg::CS_IDLE;
          if (is_read_q) begin
            res_status = mbs_pkg::ST_READ;
            if (ingrid_q) begin
              res_bits[mbs_pkg::PL_VIS] = vis_rd[cx0][0][0];
              for (int q = 0; q < NOP; q++) begin
                res_bits[mbs_pkg::PL_N+q] = opn_rd[q][cx0][0][0];
              end
            end
          end else begin
            unique case (run_q)
              mbs_pkg::RUN_DONE: res_status = mbs_pkg::ST_FINISHED;
              mbs_pkg::RUN_WALK: begin
                if (ok != 4'b0000) begin
                  if (!ok[draw_q]) begin
                    res_status = mbs_pkg::ST_REJECTED;
                  end else begin
                    walk_x_d                       = nx;
                    walk_y_d                       = ny;
                    vcnt_d                         = vcnt_q + CW'(1);
                    pl_we[mbs_pkg::PL_VIS][nx[0]] = 1'b1;
                    pl_wa[mbs_pkg::PL_VIS][nx[0]] = new_addr;
                    pl_we[here][x0]                = 1'b1;
                    pl_wa[here][x0]                = cur_addr;
                    pl_we[there][nx[0]]            = 1'b1;
                    pl_wa[there][nx[0]]            = new_addr;
                    if (depth_q < SDW'(STACK_DEPTH)) begin
                      stk_we  = 1'b1;
                      stk_wa  = depth_q[SPW-1:0];
                      stk_wd  = {ny, nx};
                      depth_d = depth_q + SDW'(1);
                    end
                    if (vcnt_d >= area) begin
                      run_d      = mbs_pkg::RUN_DONE;
                      res_status = mbs_pkg::ST_FINISHED;
                    end else begin
                      res_status = mbs_pkg::ST_CARVED;
                    end
                  end
                end else begin
                  if (depth_q != '0) begin
                    depth_d  = depth_m1;
                    walk_x_d = stk_rd[0][XW-1:0];
                    walk_y_d = stk_rd[0][XW+:YW];
                  end
                  res_status = mbs_pkg::ST_BACKTRACK;
                end
              end
              default: res_status = mbs_pkg::ST_NOT_STARTED;
            endcase
          end
        end
      end
    endcase

    if (cfg.wr) begin
      run_d = mbs_pkg::RUN_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= mbs_pkg::CS_CLEAR;
      pend_q   <= 1'b0;
      clr_q    <= '0;
      walk_x_q <= '0;
      walk_y_q <= '0;
      depth_q  <= '0;
      vcnt_q   <= '0;
      run_q    <= mbs_pkg::RUN_IDLE;
      ov_q     <= 1'b0;
    end else begin
      ctl_q    <= ctl_d;
      pend_q   <= pend_d;
      clr_q    <= clr_d;
      walk_x_q <= walk_x_d;
      walk_y_q <= walk_y_d;
      depth_q  <= depth_d;
      vcnt_q   <= vcnt_d;
      run_q    <= run_d;
      if (fire) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mode_q   <= mode_i;
      cx_q     <= cell_x_i;
      cy_q     <= cell_y_i;
      draw_q   <= draw_i;
      ingrid_q <= ingrid_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= res_status;
      obits_q  <= res_bits;
      if (is_read_q) begin
        px_q <= cx_q;
        py_q <= cy_q;
      end else begin
        px_q <= mbs_pkg::COORD_W'(walk_x_d);
        py_q <= mbs_pkg::COORD_W'(walk_y_d);
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign status_o       = status_q;
  assign pos_x_o        = px_q;
  assign pos_y_o        = py_q;
  assign open_north_o   = obits_q[mbs_pkg::PL_N];
  assign open_south_o   = obits_q[mbs_pkg::PL_S];
  assign open_east_o    = obits_q[mbs_pkg::PL_E];
  assign open_west_o    = obits_q[mbs_pkg::PL_W];
  assign cell_visited_o = obits_q[mbs_pkg::PL_VIS];

endmodule

// File: tb/sv/maze_backtracker_step_tb.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step_tb
// Self-checking testbench for the maze backtracker step block. A driver sends
// start, step and read transactions from a queue, and a monitor checks every
// result against a model of the walk, cell store and backtrack stack. Most
// step draws are picked from the open directions so that mazes get carved to
// completion. Grid sizes are changed between phases, with varied handshake
// pacing on both channels.
// ----------------------------------------------------------------------------
module maze_backtracker_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_MAX_W = 32;
  localparam int GRID_MAX_H = 32;
  localparam int NCELLS     = GRID_MAX_W * GRID_MAX_H;
  localparam int STACK_CAP  = 1024;
  localparam int MIRROR     = 0;
  localparam int LOOKAHEAD  = 1;
  localparam int QUIET_MAX  = 4000;

  localparam logic [mbs_pkg::MODE_W-1:0] MODE_READ     = 2'd2;
  localparam logic [mbs_pkg::MODE_W-1:0] MODE_READ_ALT = 2'd3;

  typedef struct packed {
    logic [mbs_pkg::MODE_W-1:0]  mode;
    logic [mbs_pkg::COORD_W-1:0] x;
    logic [mbs_pkg::COORD_W-1:0] y;
    logic [mbs_pkg::DRAW_W-1:0]  draw;
  } maze_cmd_t;

  typedef struct packed {
    mbs_pkg::status_e            status;
    logic [mbs_pkg::COORD_W-1:0] x;
    logic [mbs_pkg::COORD_W-1:0] y;
    logic                        north;
    logic                        south;
    logic                        east;
    logic                        west;
    logic                        visited;
  } maze_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mbs_pkg::PADDR_W-1:0] paddr = '0;
  logic [mbs_pkg::PDATA_W-1:0] pwdata = '0;
  logic [mbs_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [mbs_pkg::MODE_W-1:0] mode_i = '0;
  logic [mbs_pkg::COORD_W-1:0] cell_x_i = '0;
  logic [mbs_pkg::COORD_W-1:0] cell_y_i = '0;
  logic [mbs_pkg::DRAW_W-1:0] draw_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [mbs_pkg::COORD_W-1:0] pos_x_o;
  logic [mbs_pkg::COORD_W-1:0] pos_y_o;
  logic open_north_o;
  logic open_south_o;
  logic open_east_o;
  logic open_west_o;
  logic cell_visited_o;

  maze_cmd_t pending_cmds[$];
  maze_res_t due_results[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet = 0;

  // Two copies of the maze state: one follows accepted transactions, the
  // other runs ahead at generation time to choose useful draws.
  logic [mbs_pkg::NUM_PL-1:0] cells [2][NCELLS];
  logic [9:0] trail [2][STACK_CAP];
  int trail_len [2];
  int walk_x [2];
  int walk_y [2];
  int visit_cnt [2];
  mbs_pkg::run_e run_st [2];
  logic [mbs_pkg::CFG_W-1:0] grid_w [2];
  logic [mbs_pkg::CFG_W-1:0] grid_h [2];

  maze_backtracker_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .draw_i        (draw_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .open_north_o  (open_north_o),
    .open_south_o  (open_south_o),
    .open_east_o   (open_east_o),
    .open_west_o   (open_west_o),
    .cell_visited_o(cell_visited_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int grid_dim(input logic [mbs_pkg::CFG_W-1:0] v, input int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int cell_idx(input int x, input int y);
    return (y * GRID_MAX_W + x + NCELLS) % NCELLS;
  endfunction

  function automatic void push_trail(input int s, input int x, input int y);
    if (trail_len[s] < STACK_CAP) begin
      trail[s][trail_len[s]] = 10'(cell_idx(x, y));
      trail_len[s]++;
    end
  endfunction

  function automatic logic [3:0] open_dirs(input int s, input int w, input int h);
    logic [3:0] m;
    int x;
    int y;
    x = walk_x[s];
    y = walk_y[s];
    m = '0;
    m[mbs_pkg::DIR_E] = (x + 1 < w) && !cells[s][cell_idx(x + 1, y)][mbs_pkg::PL_VIS];
    m[mbs_pkg::DIR_W] = (x >= 1) && !cells[s][cell_idx(x - 1, y)][mbs_pkg::PL_VIS];
    m[mbs_pkg::DIR_S] = (y + 1 < h) && !cells[s][cell_idx(x, y + 1)][mbs_pkg::PL_VIS];
    m[mbs_pkg::DIR_N] = (y >= 1) && !cells[s][cell_idx(x, y - 1)][mbs_pkg::PL_VIS];
    return m;
  endfunction

  function automatic maze_res_t walk_item(input int s, input maze_cmd_t c);
    maze_res_t r;
    logic [3:0] m;
    logic [mbs_pkg::NUM_PL-1:0] bits;
    int w;
    int h;
    int x;
    int y;
    int nx;
    int ny;
    int hp;
    int tp;
    int top;
    w = grid_dim(grid_w[s], GRID_MAX_W);
    h = grid_dim(grid_h[s], GRID_MAX_H);
    x = int'(c.x);
    y = int'(c.y);
    bits = '0;
    r = '0;
    case (c.mode)
      mbs_pkg::MODE_START: begin
        if (x >= w) x = w - 1;
        if (y >= h) y = h - 1;
        for (int i = 0; i < NCELLS; i++) cells[s][i] = '0;
        cells[s][cell_idx(x, y)][mbs_pkg::PL_VIS] = 1'b1;
        trail_len[s] = 0;
        push_trail(s, x, y);
        walk_x[s] = x;
        walk_y[s] = y;
        visit_cnt[s] = 1;
        run_st[s] = (visit_cnt[s] >= w * h) ? mbs_pkg::RUN_DONE : mbs_pkg::RUN_WALK;
        r.status = mbs_pkg::ST_STARTED;
      end
      mbs_pkg::MODE_STEP: begin
        if (run_st[s] == mbs_pkg::RUN_IDLE) begin
          r.status = mbs_pkg::ST_NOT_STARTED;
        end else if (run_st[s] == mbs_pkg::RUN_DONE) begin
          r.status = mbs_pkg::ST_FINISHED;
        end else begin
          m = open_dirs(s, w, h);
          if (m == '0) begin
            if (trail_len[s] > 0) begin
              trail_len[s]--;
              top = int'(trail[s][trail_len[s]]);
              walk_x[s] = top % GRID_MAX_W;
              walk_y[s] = top / GRID_MAX_W;
            end
            r.status = mbs_pkg::ST_BACKTRACK;
          end else if (!m[c.draw]) begin
            r.status = mbs_pkg::ST_REJECTED;
          end else begin
            nx = walk_x[s];
            ny = walk_y[s];
            case (c.draw)
              mbs_pkg::DIR_E: begin
                nx++;
                hp = mbs_pkg::PL_E;
                tp = mbs_pkg::PL_W;
              end
              mbs_pkg::DIR_W: begin
                nx--;
                hp = mbs_pkg::PL_W;
                tp = mbs_pkg::PL_E;
              end
              mbs_pkg::DIR_S: begin
                ny++;
                hp = mbs_pkg::PL_S;
                tp = mbs_pkg::PL_N;
              end
              default: begin
                ny--;
                hp = mbs_pkg::PL_N;
                tp = mbs_pkg::PL_S;
              end
            endcase
            cells[s][cell_idx(walk_x[s], walk_y[s])][hp] = 1'b1;
            cells[s][cell_idx(nx, ny)][tp] = 1'b1;
            cells[s][cell_idx(nx, ny)][mbs_pkg::PL_VIS] = 1'b1;
            walk_x[s] = nx;
            walk_y[s] = ny;
            visit_cnt[s]++;
            push_trail(s, nx, ny);
            if (visit_cnt[s] >= w * h) begin
              run_st[s] = mbs_pkg::RUN_DONE;
              r.status = mbs_pkg::ST_FINISHED;
            end else begin
              r.status = mbs_pkg::ST_CARVED;
            end
          end
        end
      end
      default: begin
        r.status = mbs_pkg::ST_READ;
        if (x < w && y < h) bits = cells[s][cell_idx(x, y)];
      end
    endcase
    if (c.mode == mbs_pkg::MODE_START || c.mode == mbs_pkg::MODE_STEP) begin
      r.x = mbs_pkg::COORD_W'(walk_x[s]);
      r.y = mbs_pkg::COORD_W'(walk_y[s]);
    end else begin
      r.x = c.x;
      r.y = c.y;
    end
    r.north = bits[mbs_pkg::PL_N];
    r.south = bits[mbs_pkg::PL_S];
    r.east = bits[mbs_pkg::PL_E];
    r.west = bits[mbs_pkg::PL_W];
    r.visited = bits[mbs_pkg::PL_VIS];
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send(input logic [mbs_pkg::MODE_W-1:0] mode, input int x, input int y,
                      input logic [mbs_pkg::DRAW_W-1:0] draw);
    maze_cmd_t c;
    c.mode = mode;
    c.x = mbs_pkg::COORD_W'(x);
    c.y = mbs_pkg::COORD_W'(y);
    c.draw = draw;
    void'(walk_item(LOOKAHEAD, c));
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic pace(input int in_idle, input int out_stall);
    idle_pct = in_idle;
    stall_pct = out_stall;
  endtask

  task automatic write_reg(input logic idx, input logic [mbs_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {26'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    for (int s = 0; s < 2; s++) begin
      if (idx == mbs_pkg::REG_GRID_WIDTH) grid_w[s] = val;
      else grid_h[s] = val;
      run_st[s] = mbs_pkg::RUN_IDLE;
    end
  endtask

  task automatic set_grid(input logic [mbs_pkg::CFG_W-1:0] w,
                          input logic [mbs_pkg::CFG_W-1:0] h);
    drain();
    write_reg(mbs_pkg::REG_GRID_WIDTH, w);
    write_reg(mbs_pkg::REG_GRID_HEIGHT, h);
  endtask

  task automatic random_walks(input int n, input bit pause_mid);
    logic [3:0] m;
    logic [mbs_pkg::DRAW_W-1:0] d;
    logic [mbs_pkg::MODE_W-1:0] md;
    int r;
    int w;
    int h;
    bit walking;
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) drain();
      w = grid_dim(grid_w[LOOKAHEAD], GRID_MAX_W);
      h = grid_dim(grid_h[LOOKAHEAD], GRID_MAX_H);
      walking = (run_st[LOOKAHEAD] == mbs_pkg::RUN_WALK);
      r = $urandom_range(99);
      if (r < (walking ? 3 : 40)) begin
        send(mbs_pkg::MODE_START, $urandom_range(31), $urandom_range(31),
             mbs_pkg::DRAW_W'($urandom()));
      end else if (r < (walking ? 14 : 65)) begin
        md = ($urandom_range(9) == 0) ? MODE_READ_ALT : MODE_READ;
        if ($urandom_range(9) < 7) begin
          send(md, $urandom_range(w - 1), $urandom_range(h - 1),
               mbs_pkg::DRAW_W'($urandom()));
        end else begin
          send(md, $urandom_range(31), $urandom_range(31), mbs_pkg::DRAW_W'($urandom()));
        end
      end else begin
        m = open_dirs(LOOKAHEAD, w, h);
        d = mbs_pkg::DRAW_W'($urandom());
        if (m != '0 && $urandom_range(9) < 8) begin
          while (!m[d]) d = mbs_pkg::DRAW_W'($urandom());
        end
        send(mbs_pkg::MODE_STEP, $urandom_range(31), $urandom_range(31), d);
      end
    end
  endtask

  always @(posedge clk_i) begin : driver
    maze_cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        c.mode = mode_i;
        c.x = cell_x_i;
        c.y = cell_y_i;
        c.draw = draw_i;
        due_results.insert(due_results.size(), walk_item(MIRROR, c));
      end
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        c = pending_cmds.pop_front();
        mode_i <= c.mode;
        cell_x_i <= c.x;
        cell_y_i <= c.y;
        draw_i <= c.draw;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    maze_res_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report("unexpected transaction, status", status_o, 0);
        end else begin
          e = due_results.pop_front();
          if (status_o !== e.status) report("status", status_o, e.status);
          if (pos_x_o !== e.x) report("pos_x", pos_x_o, e.x);
          if (pos_y_o !== e.y) report("pos_y", pos_y_o, e.y);
          if (open_north_o !== e.north) report("open_north", open_north_o, e.north);
          if (open_south_o !== e.south) report("open_south", open_south_o, e.south);
          if (open_east_o !== e.east) report("open_east", open_east_o, e.east);
          if (open_west_o !== e.west) report("open_west", open_west_o, e.west);
          if (cell_visited_o !== e.visited) report("cell_visited", cell_visited_o, e.visited);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < NCELLS; i++) cells[s][i] = '0;
      trail_len[s] = 0;
      walk_x[s] = 0;
      walk_y[s] = 0;
      visit_cnt[s] = 0;
      run_st[s] = mbs_pkg::RUN_IDLE;
      grid_w[s] = mbs_pkg::GRID_W_RST;
      grid_h[s] = mbs_pkg::GRID_H_RST;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset grid of 16 by 8: steps before any start, reads outside the grid
    // and a start that saturates to the far corner.
    pace(8, 8);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_N);
    send(MODE_READ_ALT, 31, 31, mbs_pkg::DIR_E);
    send(MODE_READ, 0, 0, mbs_pkg::DIR_S);
    send(mbs_pkg::MODE_START, 31, 31, mbs_pkg::DIR_W);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_E);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_S);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_W);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_N);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_W);
    send(MODE_READ, 14, 6, mbs_pkg::DIR_E);
    send(MODE_READ, 15, 7, mbs_pkg::DIR_E);
    send(MODE_READ, 14, 7, mbs_pkg::DIR_E);

    // A single cell is finished as soon as it is started.
    set_grid(6'd1, 6'd1);
    send(mbs_pkg::MODE_START, 5, 9, mbs_pkg::DIR_E);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_E);
    send(MODE_READ, 0, 0, mbs_pkg::DIR_E);
    send(MODE_READ, 1, 0, mbs_pkg::DIR_E);

    // The carve that visits the last cell reports the run as finished.
    set_grid(6'd2, 6'd1);
    send(mbs_pkg::MODE_START, 1, 0, mbs_pkg::DIR_N);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_W);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_E);
    send(MODE_READ, 0, 0, mbs_pkg::DIR_E);
    send(MODE_READ, 1, 0, mbs_pkg::DIR_E);

    // Width zero and height above the maximum are clamped.
    set_grid(6'd0, 6'd63);
    send(mbs_pkg::MODE_START, 31, 31, mbs_pkg::DIR_E);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_N);
    send(mbs_pkg::MODE_STEP, 0, 0, mbs_pkg::DIR_E);
    send(MODE_READ, 0, 30, mbs_pkg::DIR_E);

    set_grid(6'd4, 6'd4);
    pace(0, 0);
    random_walks(110, 1'b0);
    set_grid(6'd5, 6'd3);
    pace(72, 0);
    random_walks(110, 1'b1);
    set_grid(6'd3, 6'd6);
    pace(0, 72);
    random_walks(110, 1'b0);
    set_grid(6'd8, 6'd8);
    pace(8, 8);
    random_walks(110, 1'b1);
    set_grid(6'd32, 6'd1);
    pace(0, 0);
    random_walks(80, 1'b0);
    set_grid(6'd2, 6'd2);
    pace(8, 8);
    random_walks(80, 1'b0);
    set_grid(6'd63, 6'd40);
    pace(0, 0);
    random_walks(150, 1'b0);
    set_grid(6'd6, 6'd5);
    pace(72, 0);
    random_walks(80, 1'b0);
    set_grid(6'd32, 6'd2);
    pace(0, 72);
    random_walks(60, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
